@@ rtl/core/sfp_pkg.sv @@
// Package with the types, constants and string tables of the STOMP frame parser.
package sfp_pkg;

  localparam int unsigned NumCmds = 15;
  localparam int unsigned NumKeys = 19;
  localparam logic [4:0] ContentLengthId = 5'd3;

  typedef enum logic [2:0] {
    PH_CMD  = 3'd0,
    PH_KEY  = 3'd1,
    PH_VAL  = 3'd2,
    PH_BODY = 3'd3,
    PH_ERR  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    LF_NONE = 3'd0,
    LF_CAPT = 3'd1,
    LF_HELD = 3'd2,
    LF_BAD  = 3'd3,
    LF_OVER = 3'd4
  } len_flag_e;

  typedef enum logic [2:0] {
    CLS_CMD   = 3'd0,
    CLS_KEY   = 3'd1,
    CLS_COLON = 3'd2,
    CLS_VAL   = 3'd3,
    CLS_EOL   = 3'd4,
    CLS_BODY  = 3'd5,
    CLS_NULL  = 3'd6,
    CLS_ERR   = 3'd7
  } byte_class_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_CMD_EOL   = 4'd1,
    ERR_CMD_BAD   = 4'd2,
    ERR_VAL_EOL   = 4'd3,
    ERR_VAL_EMPTY = 4'd4,
    ERR_KEY_BAD   = 4'd5,
    ERR_HDR_END   = 4'd6,
    ERR_NO_BLANK  = 4'd7,
    ERR_NO_NULL   = 4'd8,
    ERR_AFTER_NUL = 4'd9,
    ERR_LEN_NAN   = 4'd10,
    ERR_LEN_MISM  = 4'd11
  } err_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [3:0] CmdNone = 4'd15;

  // Command character at a position, 0 past the end of the name.
  function automatic logic [7:0] cmd_char(input logic [3:0] idx, input logic [3:0] pos);
    logic [8*11-1:0] s;
    case (idx)
      4'd0:  s = {"ABORT", 48'h0};
      4'd1:  s = {"ACK", 64'h0};
      4'd2:  s = {"BEGIN", 48'h0};
      4'd3:  s = {"COMMIT", 40'h0};
      4'd4:  s = {"CONNECT", 32'h0};
      4'd5:  s = {"CONNECTED", 16'h0};
      4'd6:  s = {"DISCONNECT", 8'h0};
      4'd7:  s = {"ERROR", 48'h0};
      4'd8:  s = {"MESSAGE", 32'h0};
      4'd9:  s = {"NACK", 56'h0};
      4'd10: s = {"RECEIPT", 32'h0};
      4'd11: s = {"SEND", 56'h0};
      4'd12: s = {"STOMP", 48'h0};
      4'd13: s = {"SUBSCRIBE", 16'h0};
      default: s = "UNSUBSCRIBE";
    endcase
    if (pos > 4'd10) begin
      return 8'h0;
    end
    return s[8*(10-pos) +: 8];
  endfunction

  function automatic logic [3:0] cmd_len(input logic [3:0] idx);
    case (idx)
      4'd0: return 4'd5;  4'd1: return 4'd3;  4'd2: return 4'd5;  4'd3: return 4'd6;
      4'd4: return 4'd7;  4'd5: return 4'd9;  4'd6: return 4'd10; 4'd7: return 4'd5;
      4'd8: return 4'd7;  4'd9: return 4'd4;  4'd10: return 4'd7; 4'd11: return 4'd4;
      4'd12: return 4'd5; 4'd13: return 4'd9; default: return 4'd11;
    endcase
  endfunction

  // Header key character at a position, 0 past the end of the key.
  function automatic logic [7:0] key_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [8*14-1:0] s;
    case (idx)
      5'd0:  s = "accept-version";
      5'd1:  s = {"ack", 88'h0};
      5'd2:  s = "content-length";
      5'd3:  s = {"content-type", 16'h0};
      5'd4:  s = {"destination", 24'h0};
      5'd5:  s = {"heart-beat", 32'h0};
      5'd6:  s = {"host", 80'h0};
      5'd7:  s = {"id", 96'h0};
      5'd8:  s = {"login", 72'h0};
      5'd9:  s = {"message", 56'h0};
      5'd10: s = {"message-id", 32'h0};
      5'd11: s = {"passcode", 48'h0};
      5'd12: s = {"receipt", 56'h0};
      5'd13: s = {"receipt-id", 32'h0};
      5'd14: s = {"session", 56'h0};
      5'd15: s = {"subscription", 16'h0};
      5'd16: s = {"transaction", 24'h0};
      5'd17: s = {"server", 64'h0};
      default: s = {"version", 56'h0};
    endcase
    if (pos > 4'd13) begin
      return 8'h0;
    end
    return s[8*(13-pos) +: 8];
  endfunction

  function automatic logic [3:0] key_len(input logic [4:0] idx);
    case (idx)
      5'd0: return 4'd14;  5'd1: return 4'd3;   5'd2: return 4'd14;  5'd3: return 4'd12;
      5'd4: return 4'd11;  5'd5: return 4'd10;  5'd6: return 4'd4;   5'd7: return 4'd2;
      5'd8: return 4'd5;   5'd9: return 4'd7;   5'd10: return 4'd10; 5'd11: return 4'd8;
      5'd12: return 4'd7;  5'd13: return 4'd10; 5'd14: return 4'd7;  5'd15: return 4'd12;
      5'd16: return 4'd11; 5'd17: return 4'd6;  default: return 4'd7;
    endcase
  endfunction

  // Byte and its last flag after the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // Outcome of the string matchers for the current byte.
  typedef struct packed {
    logic [NumCmds-1:0] cmd_live_nx;
    logic [NumKeys-1:0] key_live_nx;
    logic               cmd_hit;
    logic [3:0]         cmd_idx;
    logic               key_hit;
    logic [4:0]         key_idx;
  } match_t;

endpackage

@@ rtl/core/sfp_in_if.sv @@
// Input and result channel interfaces of the STOMP frame parser.
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       last;
  modport source (output valid, data, last, input ready);
  modport sink (input valid, data, last, output ready);
endinterface

interface sfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [4:0]  header_id;
  logic        frame_done;
  logic [3:0]  status;
  logic [3:0]  command;
  logic [31:0] body_length;
  logic        length_given;
  modport source (output valid, byte_class, header_id, frame_done, status, command,
                  body_length, length_given, input ready);
  modport sink (input valid, byte_class, header_id, frame_done, status, command,
                body_length, length_given, output ready);
endinterface

@@ rtl/core/stomp_frame_parser.sv @@
// STOMP frame parser: input register, frame state machine, result register.
// Takes one frame byte per cycle while the result side keeps up and gives
// one result item per byte, via the input then the result register. The
// input register and the result register each hold one item and move
// together, so a byte is taken in every cycle the result side keeps up; the
// command and key matchers are parallel comparators against constant tables.
module stomp_frame_parser #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  sfp_in_if.sink    in_i,
  sfp_out_if.source out_o
);

  localparam int unsigned CmpW = (LEN_WIDTH > 32) ? LEN_WIDTH : 32;
  localparam int unsigned ExtW = LEN_WIDTH + 4;

  // Handshake of the two register stages.
  logic             in_vld_q;
  sfp_pkg::in_item_t in_q;
  logic             adv;

  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= '{data: in_i.data, last: in_i.last};
    end
  end

  // Frame state.
  sfp_pkg::phase_e    phase_q, phase_d;
  sfp_pkg::len_flag_e lf_q, lf_d;
  logic [sfp_pkg::NumCmds-1:0] cmd_live_q, cmd_live_d;
  logic [sfp_pkg::NumKeys-1:0] key_live_q, key_live_d;
  logic [3:0]  pos_q, pos_d;
  logic [4:0]  hdr_q, hdr_d;
  logic        nonempty_q, nonempty_d;
  logic [LEN_WIDTH-1:0] len_q, len_d;
  logic [31:0] body_q, body_d;
  logic        null_q, null_d;
  logic [3:0]  err_q, err_d;
  logic [3:0]  cmd_q, cmd_d;

  sfp_pkg::match_t m;

  sfp_match u_match (
    .data_i     (in_q.data),
    .pos_i      (pos_q),
    .cmd_live_i (cmd_live_q),
    .key_live_i (key_live_q),
    .match_o    (m)
  );

  logic [2:0] cls;
  logic [4:0] hid;
  logic [3:0] dig;
  logic       is_dig;
  logic       fits;
  logic       step;
  logic [ExtW-1:0] len_nx;

  assign step   = in_vld_q && adv;
  assign dig    = 4'(in_q.data - 8'h30);
  assign is_dig = in_q.data >= 8'h30 && in_q.data <= 8'h39;
  // The value times ten plus the digit, built from two shifts; it fits when
  // nothing spills above the value width.
  assign len_nx = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + ExtW'(dig);
  assign fits   = len_nx[ExtW-1:LEN_WIDTH] == 4'd0;

  // Next state for one byte.
  always_comb begin
    phase_d = phase_q; lf_d = lf_q; cmd_live_d = cmd_live_q; key_live_d = key_live_q;
    pos_d = pos_q; hdr_d = hdr_q; nonempty_d = nonempty_q; len_d = len_q;
    body_d = body_q; null_d = null_q; err_d = err_q; cmd_d = cmd_q;
    cls = sfp_pkg::CLS_ERR; hid = '0;
    unique case (phase_q)
      sfp_pkg::PH_CMD: begin
        if (in_q.data == sfp_pkg::ChLf) begin
          cls = sfp_pkg::CLS_EOL;
          if (!m.cmd_hit) begin
            err_d = sfp_pkg::ERR_CMD_BAD; phase_d = sfp_pkg::PH_ERR;
          end else begin
            cmd_d = m.cmd_idx;
            if (in_q.last) begin
              err_d = sfp_pkg::ERR_NO_BLANK; phase_d = sfp_pkg::PH_ERR;
            end else begin
              phase_d = sfp_pkg::PH_KEY; pos_d = '0; key_live_d = '1;
              hdr_d = '0; nonempty_d = 1'b0;
            end
          end
        end else begin
          cls = sfp_pkg::CLS_CMD;
          cmd_live_d = m.cmd_live_nx;
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          if (in_q.last) begin
            err_d = sfp_pkg::ERR_CMD_EOL; phase_d = sfp_pkg::PH_ERR;
          end
        end
      end
      sfp_pkg::PH_KEY: begin
        if (in_q.data == sfp_pkg::ChLf) begin
          cls = sfp_pkg::CLS_EOL;
          if (pos_q == '0) begin
            phase_d = sfp_pkg::PH_BODY;
            if (in_q.last) begin
              err_d = sfp_pkg::ERR_NO_NULL; phase_d = sfp_pkg::PH_ERR;
            end
          end else begin
            err_d = sfp_pkg::ERR_NO_BLANK; phase_d = sfp_pkg::PH_ERR;
          end
        end else if (in_q.data == sfp_pkg::ChColon) begin
          cls = sfp_pkg::CLS_COLON;
          hdr_d = m.key_hit ? m.key_idx + 5'd1 : 5'd0;
          nonempty_d = 1'b0;
          phase_d = sfp_pkg::PH_VAL;
          if (hdr_d == sfp_pkg::ContentLengthId && lf_q == sfp_pkg::LF_NONE)
            lf_d = sfp_pkg::LF_CAPT;
          if (in_q.last) begin
            err_d = sfp_pkg::ERR_VAL_EOL; phase_d = sfp_pkg::PH_ERR;
          end
        end else begin
          cls = sfp_pkg::CLS_KEY;
          key_live_d = m.key_live_nx;
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          if (in_q.last) begin
            err_d = sfp_pkg::ERR_NO_BLANK; phase_d = sfp_pkg::PH_ERR;
          end
        end
      end
      sfp_pkg::PH_VAL: begin
        if (in_q.data == sfp_pkg::ChLf) begin
          cls = sfp_pkg::CLS_EOL;
          if (lf_q == sfp_pkg::LF_CAPT)
            lf_d = nonempty_q ? sfp_pkg::LF_HELD : sfp_pkg::LF_BAD;
          if (!nonempty_q) begin
            err_d = sfp_pkg::ERR_VAL_EMPTY; phase_d = sfp_pkg::PH_ERR;
          end else if (hdr_q == '0) begin
            err_d = sfp_pkg::ERR_KEY_BAD; phase_d = sfp_pkg::PH_ERR;
          end else if (in_q.last) begin
            err_d = sfp_pkg::ERR_HDR_END; phase_d = sfp_pkg::PH_ERR;
          end else begin
            phase_d = sfp_pkg::PH_KEY; pos_d = '0; key_live_d = '1;
            hdr_d = '0; nonempty_d = 1'b0;
          end
        end else begin
          cls = sfp_pkg::CLS_VAL;
          hid = hdr_q;
          if (lf_q == sfp_pkg::LF_CAPT) begin
            if (is_dig) begin
              if (fits) len_d = len_nx[LEN_WIDTH-1:0];
              else lf_d = sfp_pkg::LF_OVER;
            end else begin
              lf_d = nonempty_q ? sfp_pkg::LF_HELD : sfp_pkg::LF_BAD;
            end
          end
          nonempty_d = 1'b1;
          if (in_q.last) begin
            err_d = sfp_pkg::ERR_VAL_EOL; phase_d = sfp_pkg::PH_ERR;
          end
        end
      end
      sfp_pkg::PH_BODY: begin
        if (null_q) begin
          cls = (in_q.data == sfp_pkg::ChNul) ? sfp_pkg::CLS_NULL : sfp_pkg::CLS_BODY;
          err_d = sfp_pkg::ERR_AFTER_NUL; phase_d = sfp_pkg::PH_ERR;
        end else if (in_q.data == sfp_pkg::ChNul) begin
          cls = sfp_pkg::CLS_NULL;
          null_d = 1'b1;
          if (in_q.last) begin
            if (lf_q == sfp_pkg::LF_BAD) begin
              err_d = sfp_pkg::ERR_LEN_NAN;
            end else if (lf_q == sfp_pkg::LF_OVER) begin
              err_d = sfp_pkg::ERR_LEN_MISM;
            end else if (lf_q != sfp_pkg::LF_NONE
                         && CmpW'(len_q) != CmpW'(body_q)) begin
              err_d = sfp_pkg::ERR_LEN_MISM;
            end
          end
        end else begin
          cls = sfp_pkg::CLS_BODY;
          if (body_q != '1) body_d = body_q + 32'd1;
          if (in_q.last) begin
            err_d = sfp_pkg::ERR_NO_NULL; phase_d = sfp_pkg::PH_ERR;
          end
        end
      end
      default: cls = sfp_pkg::CLS_ERR;
    endcase
    // The first error latches: a later one never overwrites it.
    if (err_q != sfp_pkg::ERR_NONE) err_d = err_q;
  end

  // State registers; a last byte restores the reset state for the next frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfp_pkg::PH_CMD; lf_q <= sfp_pkg::LF_NONE;
      cmd_live_q <= '1; key_live_q <= '1; pos_q <= '0; hdr_q <= '0;
      nonempty_q <= 1'b0; len_q <= '0; body_q <= '0; null_q <= 1'b0;
      err_q <= sfp_pkg::ERR_NONE; cmd_q <= sfp_pkg::CmdNone;
    end else if (step) begin
      if (in_q.last) begin
        phase_q <= sfp_pkg::PH_CMD; lf_q <= sfp_pkg::LF_NONE;
        cmd_live_q <= '1; key_live_q <= '1; pos_q <= '0; hdr_q <= '0;
        nonempty_q <= 1'b0; len_q <= '0; body_q <= '0; null_q <= 1'b0;
        err_q <= sfp_pkg::ERR_NONE; cmd_q <= sfp_pkg::CmdNone;
      end else begin
        phase_q <= phase_d; lf_q <= lf_d; cmd_live_q <= cmd_live_d;
        key_live_q <= key_live_d; pos_q <= pos_d; hdr_q <= hdr_d;
        nonempty_q <= nonempty_d; len_q <= len_d; body_q <= body_d;
        null_q <= null_d; err_q <= err_d; cmd_q <= cmd_d;
      end
    end
  end

  // Result register.
  logic out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_o.byte_class   <= cls;
      out_o.header_id    <= hid;
      out_o.frame_done   <= in_q.last;
      out_o.status       <= in_q.last ? err_d : 4'd0;
      out_o.command      <= in_q.last ? cmd_d : 4'd0;
      out_o.body_length  <= in_q.last ? body_d : 32'd0;
      out_o.length_given <= in_q.last && (lf_d != sfp_pkg::LF_NONE);
    end
  end

  assign out_o.valid = out_vld_q;

endmodule

@@ rtl/core/sfp_match.sv @@
// Parallel command and header key matchers that narrow candidate sets.
module sfp_match (
  input  logic [7:0]                  data_i,
  input  logic [3:0]                  pos_i,
  input  logic [sfp_pkg::NumCmds-1:0] cmd_live_i,
  input  logic [sfp_pkg::NumKeys-1:0] key_live_i,
  output sfp_pkg::match_t             match_o
);

  // Narrow on the current byte and pick a live candidate of matching length.
  always_comb begin
    match_o = '0;
    for (int i = 0; i < sfp_pkg::NumCmds; i++) begin
      match_o.cmd_live_nx[i] = cmd_live_i[i] && (pos_i < sfp_pkg::cmd_len(4'(i)))
          && (sfp_pkg::cmd_char(4'(i), pos_i) == data_i);
    end
    for (int i = sfp_pkg::NumCmds - 1; i >= 0; i--) begin
      if (cmd_live_i[i] && sfp_pkg::cmd_len(4'(i)) == pos_i) begin
        match_o.cmd_hit = 1'b1;
        match_o.cmd_idx = 4'(i);
      end
    end
    for (int i = 0; i < sfp_pkg::NumKeys; i++) begin
      match_o.key_live_nx[i] = key_live_i[i] && (pos_i < sfp_pkg::key_len(5'(i)))
          && (sfp_pkg::key_char(5'(i), pos_i) == data_i);
    end
    for (int i = sfp_pkg::NumKeys - 1; i >= 0; i--) begin
      if (key_live_i[i] && sfp_pkg::key_len(5'(i)) == pos_i) begin
        match_o.key_hit = 1'b1;
        match_o.key_idx = 5'(i);
      end
    end
  end

endmodule

@@ tb/tb_stomp_frame_parser.sv @@
// Testbench for the STOMP frame parser: frame byte stimulus, a byte-level predictor and a scoreboard.
`timescale 1ns / 1ps

module tb_stomp_frame_parser;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic [2:0]  byte_class;
    logic [4:0]  header_id;
    logic        frame_done;
    logic [3:0]  status;
    logic [3:0]  command;
    logic [31:0] body_length;
    logic        length_given;
  } verdict_t;

  // Queue of predicted results, checked in order against the block.
  class verdict_board;
    verdict_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    function void note_byte(verdict_t v);
      pending.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d: expected cls=%0d hid=%0d done=%0d st=%0d cmd=%0d len=%0d lg=%0d",
                   checked, want.byte_class, want.header_id, want.frame_done, want.status,
                   want.command, want.body_length, want.length_given);
          $display("                         actual   cls=%0d hid=%0d done=%0d st=%0d cmd=%0d len=%0d lg=%0d",
                   got.byte_class, got.header_id, got.frame_done, got.status,
                   got.command, got.body_length, got.length_given);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sfp_in_if  in_ch();
  sfp_out_if out_ch();

  stomp_frame_parser u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Command and key tables of the predictor.
  string cmd_names[15] = '{"ABORT", "ACK", "BEGIN", "COMMIT", "CONNECT", "CONNECTED",
    "DISCONNECT", "ERROR", "MESSAGE", "NACK", "RECEIPT", "SEND", "STOMP", "SUBSCRIBE",
    "UNSUBSCRIBE"};
  string key_names[19] = '{"accept-version", "ack", "content-length", "content-type",
    "destination", "heart-beat", "host", "id", "login", "message", "message-id",
    "passcode", "receipt", "receipt-id", "session", "subscription", "transaction",
    "server", "version"};

  // Predictor state for the frame in progress.
  sfp_pkg::phase_e    pr_phase;
  logic [14:0]        pr_cmd_live;
  logic [18:0]        pr_key_live;
  logic [3:0]         pr_pos;
  logic [4:0]         pr_header;
  logic               pr_val_seen;
  logic [32:0]        pr_len;
  sfp_pkg::len_flag_e pr_len_flag;
  logic [31:0]        pr_body;
  logic               pr_null;
  sfp_pkg::err_e      pr_err;
  logic [3:0]         pr_cmd;

  function automatic void clear_frame_state();
    pr_phase = sfp_pkg::PH_CMD;
    pr_cmd_live = '1;
    pr_key_live = '1;
    pr_pos = '0;
    pr_header = '0;
    pr_val_seen = 1'b0;
    pr_len = '0;
    pr_len_flag = sfp_pkg::LF_NONE;
    pr_body = '0;
    pr_null = 1'b0;
    pr_err = sfp_pkg::ERR_NONE;
    pr_cmd = sfp_pkg::CmdNone;
  endfunction

  function automatic void latch_error(sfp_pkg::err_e code);
    if (pr_err == sfp_pkg::ERR_NONE) pr_err = code;
    pr_phase = sfp_pkg::PH_ERR;
  endfunction

  function automatic void start_header_line();
    pr_phase = sfp_pkg::PH_KEY;
    pr_pos = '0;
    pr_key_live = '1;
    pr_header = '0;
    pr_val_seen = 1'b0;
  endfunction

  // Index of the surviving command or key whose length equals the position, else -1.
  function automatic int cmd_match();
    for (int i = 0; i < 15; i++)
      if (pr_cmd_live[i] && cmd_names[i].len() == pr_pos) return i;
    return -1;
  endfunction

  function automatic int key_match();
    for (int i = 0; i < 19; i++)
      if (pr_key_live[i] && key_names[i].len() == pr_pos) return i;
    return -1;
  endfunction

  function automatic void accumulate_length(logic [7:0] ch);
    logic [32:0] d;
    if (ch >= "0" && ch <= "9") begin
      d = 33'(ch - 8'h30);
      if (pr_len > (33'hFFFF_FFFF - d) / 10) pr_len_flag = sfp_pkg::LF_OVER;
      else pr_len = 33'(pr_len * 10 + d);
    end else begin
      pr_len_flag = pr_val_seen ? sfp_pkg::LF_HELD : sfp_pkg::LF_BAD;
    end
  endfunction

  // Works out the result of one frame byte and advances the predictor.
  function automatic verdict_t parse_byte(logic [7:0] ch, logic last);
    verdict_t v;
    int k;
    v = '0;
    v.byte_class = sfp_pkg::CLS_ERR;
    case (pr_phase)
      sfp_pkg::PH_CMD: begin
        if (ch == sfp_pkg::ChLf) begin
          v.byte_class = sfp_pkg::CLS_EOL;
          k = cmd_match();
          if (k < 0) latch_error(sfp_pkg::ERR_CMD_BAD);
          else begin
            pr_cmd = 4'(k);
            if (last) latch_error(sfp_pkg::ERR_NO_BLANK); else start_header_line();
          end
        end else begin
          v.byte_class = sfp_pkg::CLS_CMD;
          for (int i = 0; i < 15; i++)
            if (pr_pos >= cmd_names[i].len() || cmd_names[i][pr_pos] != ch)
              pr_cmd_live[i] = 1'b0;
          if (pr_pos < 15) pr_pos++;
          if (last) latch_error(sfp_pkg::ERR_CMD_EOL);
        end
      end
      sfp_pkg::PH_KEY: begin
        if (ch == sfp_pkg::ChLf) begin
          v.byte_class = sfp_pkg::CLS_EOL;
          if (pr_pos == 0) begin
            pr_phase = sfp_pkg::PH_BODY;
            if (last) latch_error(sfp_pkg::ERR_NO_NULL);
          end else latch_error(sfp_pkg::ERR_NO_BLANK);
        end else if (ch == sfp_pkg::ChColon) begin
          v.byte_class = sfp_pkg::CLS_COLON;
          k = key_match();
          pr_header = (k < 0) ? 5'd0 : 5'(k + 1);
          pr_val_seen = 1'b0;
          pr_phase = sfp_pkg::PH_VAL;
          if (pr_header == sfp_pkg::ContentLengthId && pr_len_flag == sfp_pkg::LF_NONE)
            pr_len_flag = sfp_pkg::LF_CAPT;
          if (last) latch_error(sfp_pkg::ERR_VAL_EOL);
        end else begin
          v.byte_class = sfp_pkg::CLS_KEY;
          for (int i = 0; i < 19; i++)
            if (pr_pos >= key_names[i].len() || key_names[i][pr_pos] != ch)
              pr_key_live[i] = 1'b0;
          if (pr_pos < 15) pr_pos++;
          if (last) latch_error(sfp_pkg::ERR_NO_BLANK);
        end
      end
      sfp_pkg::PH_VAL: begin
        if (ch == sfp_pkg::ChLf) begin
          v.byte_class = sfp_pkg::CLS_EOL;
          if (pr_len_flag == sfp_pkg::LF_CAPT)
            pr_len_flag = pr_val_seen ? sfp_pkg::LF_HELD : sfp_pkg::LF_BAD;
          if (!pr_val_seen) latch_error(sfp_pkg::ERR_VAL_EMPTY);
          else if (pr_header == 0) latch_error(sfp_pkg::ERR_KEY_BAD);
          else if (last) latch_error(sfp_pkg::ERR_HDR_END);
          else start_header_line();
        end else begin
          v.byte_class = sfp_pkg::CLS_VAL;
          v.header_id = pr_header;
          if (pr_len_flag == sfp_pkg::LF_CAPT) accumulate_length(ch);
          pr_val_seen = 1'b1;
          if (last) latch_error(sfp_pkg::ERR_VAL_EOL);
        end
      end
      sfp_pkg::PH_BODY: begin
        if (pr_null) begin
          v.byte_class = (ch == sfp_pkg::ChNul) ? sfp_pkg::CLS_NULL : sfp_pkg::CLS_BODY;
          latch_error(sfp_pkg::ERR_AFTER_NUL);
        end else if (ch == sfp_pkg::ChNul) begin
          v.byte_class = sfp_pkg::CLS_NULL;
          pr_null = 1'b1;
          if (last) begin
            if (pr_len_flag == sfp_pkg::LF_BAD) latch_error(sfp_pkg::ERR_LEN_NAN);
            else if (pr_len_flag == sfp_pkg::LF_OVER) latch_error(sfp_pkg::ERR_LEN_MISM);
            else if (pr_len_flag != sfp_pkg::LF_NONE && pr_len != {1'b0, pr_body})
              latch_error(sfp_pkg::ERR_LEN_MISM);
          end
        end else begin
          v.byte_class = sfp_pkg::CLS_BODY;
          if (pr_body != 32'hFFFF_FFFF) pr_body++;
          if (last) latch_error(sfp_pkg::ERR_NO_NULL);
        end
      end
      default: v.byte_class = sfp_pkg::CLS_ERR;
    endcase
    if (last) begin
      v.frame_done = 1'b1;
      v.status = pr_err;
      v.command = pr_cmd;
      v.body_length = pr_body;
      v.length_given = (pr_len_flag != sfp_pkg::LF_NONE);
      clear_frame_state();
    end
    return v;
  endfunction

  verdict_board board = new();
  bit calm;
  int unsigned bytes_sent, frames_sent;

  // Sends one byte, with a random idle burst in front of it now and then.
  task automatic send_byte(logic [7:0] ch, logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= ch;
    in_ch.last <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_byte(parse_byte(ch, last));
    bytes_sent++;
  endtask

  task automatic send_frame(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    frames_sent++;
  endtask

  // Body text of n random nonzero bytes and a closing null.
  function automatic string body_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(1, 255)))};
    return {s, string'(byte'(0))};
  endfunction

  function automatic string pick_key();
    string k;
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return key_names[$urandom_range(0, 18)];
    if (r == 7) return "x-custom";
    k = key_names[$urandom_range(0, 18)];
    k[$urandom_range(0, k.len() - 1)] = byte'($urandom_range(33, 126));
    return k;
  endfunction

  // Mostly well-formed frames, with some corruption and plain noise.
  function automatic string random_frame();
    string s, cmd, val;
    int n, hdrs, r, sel;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      s = "";
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(0, 255)))};
      return s;
    end
    cmd = cmd_names[$urandom_range(0, 14)];
    if (r == 1) cmd = {cmd, "X"};
    s = {cmd, "\n"};
    n = $urandom_range(0, 8);
    hdrs = $urandom_range(0, 3);
    for (int h = 0; h < hdrs; h++) begin
      sel = $urandom_range(0, 5);
      if (sel < 2) begin
        val = $sformatf("%0d", ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : n);
        s = {s, "content-length:", val, "\n"};
      end else if (sel == 2) begin
        if ($urandom_range(0, 1) != 0) val = "abc";
        else val = "99999999999";
        s = {s, "content-length:", val, "\n"};
      end else begin
        if ($urandom_range(0, 9) == 0) val = "";
        else val = "v1";
        s = {s, pick_key(), ":", val, "\n"};
      end
    end
    s = {s, "\n", body_text(n)};
    if (r == 2) s = {s, string'(byte'($urandom_range(0, 255)))};
    if (r == 3) s = s.substr(0, $urandom_range(0, s.len() - 2));
    return s;
  endfunction

  // Result side: random stall bursts, none in the last part of the run.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_verdict({out_ch.byte_class, out_ch.header_id, out_ch.frame_done,
                           out_ch.status, out_ch.command, out_ch.body_length,
                           out_ch.length_given});
  end

  // Main sequence: reset, directed frames, random frames, drain.
  initial begin
    int wait_cycles;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    in_ch.last = 1'b0;
    calm = 0;
    clear_frame_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame({"SEND\ncontent-length:2\n\nhi", string'(byte'(0))});
    send_frame({"UNSUBSCRIBE\naccept-version:1.2\nid:7\n\n", string'(byte'(0))});
    send_frame("SEN");
    send_frame({"FOO\n\n", string'(byte'(0))});
    send_frame("ACK\nid:1");
    send_frame({"ACK\nid:\n\n", string'(byte'(0))});
    send_frame({"ACK\nbogus:1\n\n", string'(byte'(0))});
    send_frame("ACK\nid:1\n");
    send_frame({"ACK\nnocolon\n\n", string'(byte'(0))});
    send_frame("NACK\n\nab");
    send_frame({"SEND\n\n", string'(byte'(0)), string'(byte'(0))});
    send_frame({"SEND\ncontent-length:x\n\n", string'(byte'(0))});
    send_frame({"SEND\ncontent-length:4294967296\n\n", string'(byte'(0))});
    send_frame({"SEND\ncontent-length:4294967295z\ncontent-length:0\n\n\xff",
                string'(byte'(0))});
    send_frame({"STOMP\n\n", string'(byte'(0)), "\x80"});
    send_frame("\n");
    send_frame("ACK\n");

    while (bytes_sent < 1800) begin
      if (bytes_sent > 1500) calm = 1;
      send_frame(random_frame());
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    $display("covered %0d frames in %0d bytes, %0d results checked",
             frames_sent, bytes_sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
